// ===== hdl/two_list_merge_by_frequency_assert.svh =====
// assertion macros for the rtl
`ifndef TWO_LIST_MERGE_BY_FREQUENCY_ASSERT_SVH
`define TWO_LIST_MERGE_BY_FREQUENCY_ASSERT_SVH

`ifndef SYNTHESIS

// consequence must hold in the same cycle
`define TLM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlm check failed");

// consequence must hold in the next cycle
`define TLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlm check failed");

`else

`define TLM_ASSERT_NOW(label, clk, rst, ante, cons)
`define TLM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/tlm_pkg.sv =====
package tlm_pkg;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MERGE         = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  typedef struct packed {
    logic [15:0] doc_id;
    logic [15:0] frequency;
  } entry_t;

endpackage

// ===== hdl/tlm_list.sv =====
module tlm_list import tlm_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        wdata,
  input  logic          clear,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata,
  output logic [CW-1:0] count,
  output logic          full
);

  entry_t mem [DEPTH];

  assign full = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (push && !full) begin
      count <= count + CW'(1);
    end
  end

  // dropped pushes leave the store alone
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[count[AW-1:0]] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/two_list_merge_by_frequency.sv =====
// Two-list merge by frequency. An item is taken at a rising edge with start high and busy
// low. An append (opcode 0 or 1) leaves busy low, so appends go in back to back. A merge
// (opcode 2) raises busy until its last result is chosen, or for a single marker result
// when both lists are empty, emitting one result per cycle; each result appears on the
// output ports, marked by strobe, in the cycle after it is chosen. The rate is set by the
// single head compare and the one read port of each list store. Results cannot be stalled:
// the receiver must take every transfer in the cycle strobe is high.
`include "two_list_merge_by_frequency_assert.svh"

module two_list_merge_by_frequency import tlm_pkg::*; #(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] doc_id,
  input  logic [15:0] frequency,
  output logic        strobe,
  output logic [15:0] out_doc_id,
  output logic [15:0] out_frequency,
  output logic        from_second,
  output logic        is_last,
  output logic        no_entry,
  output logic        overflowed
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  state_t        state, state_next;
  logic [CW-1:0] i, i_next, i_adv;
  logic [CW-1:0] j, j_next, j_adv;
  logic          overflow;

  logic          accept;
  logic          push_first, push_second;
  logic          full_first, full_second;
  logic [CW-1:0] count_first, count_second;
  entry_t        head_first, head_second;
  entry_t        wdata;

  logic          first_left, second_left, take_first;
  logic          emit, last, mark;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign wdata  = '{doc_id: doc_id, frequency: frequency};

  always_comb begin
    push_first  = 1'b0;
    push_second = 1'b0;
    case (opcode)
      OP_APPEND_FIRST:  push_first  = accept;
      OP_APPEND_SECOND: push_second = accept;
      default: ;
    endcase
  end

  tlm_list #(.DEPTH(LIST_DEPTH)) u_first (
    .clk   (clk),
    .rst   (rst),
    .push  (push_first),
    .wdata (wdata),
    .clear (emit && last),
    .raddr (i_next[AW-1:0]),
    .rdata (head_first),
    .count (count_first),
    .full  (full_first)
  );

  tlm_list #(.DEPTH(LIST_DEPTH)) u_second (
    .clk   (clk),
    .rst   (rst),
    .push  (push_second),
    .wdata (wdata),
    .clear (emit && last),
    .raddr (j_next[AW-1:0]),
    .rdata (head_second),
    .count (count_second),
    .full  (full_second)
  );

  // heads are read at the next index, so they are ready the cycle after a pick
  assign first_left  = (i < count_first);
  assign second_left = (j < count_second);
  assign take_first  = first_left &&
                       (!second_left || (head_first.frequency >= head_second.frequency));

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    mark       = 1'b0;
    last       = 1'b0;
    i_adv      = i;
    j_adv      = j;
    unique case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_MERGE)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        emit = 1'b1;
        if (!first_left && !second_left) begin
          mark = 1'b1;
          last = 1'b1;
        end else begin
          if (take_first) begin
            i_adv = i + CW'(1);
          end else begin
            j_adv = j + CW'(1);
          end
          last = (i_adv == count_first) && (j_adv == count_second);
        end
      end
      default: state_next = ST_IDLE;
    endcase
    i_next = i_adv;
    j_next = j_adv;
    if (emit && last) begin
      state_next = ST_IDLE;
      i_next     = '0;
      j_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      i        <= '0;
      j        <= '0;
      overflow <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      i      <= i_next;
      j      <= j_next;
      strobe <= emit;
      if (emit && last) begin
        overflow <= 1'b0;
      end else if ((push_first && full_first) || (push_second && full_second)) begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_doc_id    <= mark ? 16'd0 : (take_first ? head_first.doc_id : head_second.doc_id);
      out_frequency <= mark ? 16'd0 :
                       (take_first ? head_first.frequency : head_second.frequency);
      from_second   <= !mark && !take_first;
      is_last       <= last;
      no_entry      <= mark;
      overflowed    <= overflow;
    end
  end

  `TLM_ASSERT_NEXT(a_merge_busy, clk, rst, accept && (opcode == OP_MERGE), busy)
  `TLM_ASSERT_NOW(a_marker_last, clk, rst, strobe && no_entry, is_last && !from_second)
  `TLM_ASSERT_NOW(a_last_frees, clk, rst, strobe && is_last, !busy)
  `TLM_ASSERT_NOW(a_more_busy, clk, rst, strobe && !is_last, busy)

endmodule

// ===== dv/tb_two_list_merge_by_frequency.sv =====
module tb_two_list_merge_by_frequency;
  import tlm_pkg::*;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS = 380;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  // opcode three is not in the package, the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [15:0] doc_id;
    logic [15:0] frequency;
    logic        from_second;
    logic        is_last;
    logic        no_entry;
    logic        overflowed;
  } merged_t;

  typedef entry_t entry_q_t[$];

  class merge_scoreboard;
    entry_t  first_list[DEPTH];
    entry_t  second_list[DEPTH];
    int      first_len;
    int      second_len;
    bit      dropped;
    merged_t pending[$];
    int      errors;

    function new();
      first_len = 0;
      second_len = 0;
      dropped = 0;
      errors = 0;
    endfunction

    function void merge_lists();
      int      i;
      int      j;
      int      total;
      merged_t r;
      i = 0;
      j = 0;
      total = first_len + second_len;
      if (total == 0) begin
        r = '{16'd0, 16'd0, 1'b0, 1'b1, 1'b1, dropped};
        pending.insert(pending.size(), r);
      end
      while (i < first_len || j < second_len) begin
        // ties go to the first list
        if (j >= second_len ||
            (i < first_len && first_list[i].frequency >= second_list[j].frequency)) begin
          r.doc_id = first_list[i].doc_id;
          r.frequency = first_list[i].frequency;
          r.from_second = 1'b0;
          i++;
        end else begin
          r.doc_id = second_list[j].doc_id;
          r.frequency = second_list[j].frequency;
          r.from_second = 1'b1;
          j++;
        end
        r.is_last = (i + j == total);
        r.no_entry = 1'b0;
        r.overflowed = dropped;
        pending.insert(pending.size(), r);
      end
      first_len = 0;
      second_len = 0;
      dropped = 0;
    endfunction

    function void take_item(logic [1:0] code, logic [15:0] doc, logic [15:0] freq);
      entry_t e;
      e.doc_id = doc;
      e.frequency = freq;
      case (code)
        OP_APPEND_FIRST: begin
          if (first_len < DEPTH) begin
            first_list[first_len] = e;
            first_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        OP_APPEND_SECOND: begin
          if (second_len < DEPTH) begin
            second_list[second_len] = e;
            second_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        OP_MERGE: merge_lists();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(merged_t got);
      merged_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result doc_id %h frequency %h", $time,
                 got.doc_id, got.frequency);
        return;
      end
      want = pending.pop_front();
      compare_field("out_doc_id", want.doc_id, got.doc_id);
      compare_field("out_frequency", want.frequency, got.frequency);
      compare_field("from_second", 16'(want.from_second), 16'(got.from_second));
      compare_field("is_last", 16'(want.is_last), 16'(got.is_last));
      compare_field("no_entry", 16'(want.no_entry), 16'(got.no_entry));
      compare_field("overflowed", 16'(want.overflowed), 16'(got.overflowed));
    endfunction

    function void report_leftover();
      if (pending.size() > 0) begin
        errors += pending.size();
        $display("%0t: %0d expected results never arrived", $time, pending.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = 2'd0;
  logic [15:0] doc_id = 16'd0;
  logic [15:0] frequency = 16'd0;
  logic        busy;
  logic        strobe;
  logic [15:0] out_doc_id;
  logic [15:0] out_frequency;
  logic        from_second;
  logic        is_last;
  logic        no_entry;
  logic        overflowed;

  merge_scoreboard sb;
  merged_t         seen;
  int              cycle_count = 0;
  int              items_sent = 0;
  bit              no_idle = 1'b0;

  two_list_merge_by_frequency #(.LIST_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .doc_id(doc_id),
    .frequency(frequency),
    .strobe(strobe),
    .out_doc_id(out_doc_id),
    .out_frequency(out_frequency),
    .from_second(from_second),
    .is_last(is_last),
    .no_entry(no_entry),
    .overflowed(overflowed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      seen = '{out_doc_id, out_frequency, from_second, is_last, no_entry, overflowed};
      sb.check_result(seen);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic [1:0] code, logic [15:0] doc, logic [15:0] freq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      opcode <= 2'($urandom);
      doc_id <= 16'($urandom);
      frequency <= 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    opcode <= code;
    doc_id <= doc;
    frequency <= freq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_item(code, doc, freq);
    if (code != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // descending frequencies from a shared top, or random order when shuffled
  function automatic entry_q_t build_list(int n, int top, int step_max, bit shuffled);
    entry_q_t q;
    entry_t   e;
    int       step;
    for (int k = 0; k < n; k++) begin
      e.doc_id = 16'($urandom);
      if (shuffled) begin
        e.frequency = 16'($urandom);
      end else begin
        e.frequency = 16'(top);
        step = $urandom_range(0, step_max);
        top = (top > step) ? top - step : 0;
      end
      q.insert(q.size(), e);
    end
    return q;
  endfunction

  task automatic run_batch(bit fill_both);
    int       n1;
    int       n2;
    int       shape;
    int       top;
    int       step_max;
    entry_q_t la;
    entry_q_t lb;
    shape = $urandom_range(0, 19);
    if (fill_both) begin
      n1 = DEPTH + $urandom_range(1, 3);
      n2 = DEPTH + $urandom_range(1, 3);
    end else if (shape == 0) begin
      n1 = DEPTH + $urandom_range(0, 3);
      n2 = $urandom_range(0, DEPTH + 2);
    end else if (shape <= 2) begin
      n1 = $urandom_range(0, DEPTH);
      n2 = $urandom_range(0, DEPTH);
    end else begin
      n1 = $urandom_range(0, 6);
      n2 = $urandom_range(0, 6);
    end
    top = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 65535);
    // small steps make many equal frequencies across the lists
    step_max = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 8000);
    la = build_list(n1, top, step_max, $urandom_range(0, 5) == 0);
    lb = build_list(n2, top, step_max, $urandom_range(0, 5) == 0);
    no_idle = ($urandom_range(0, 3) == 0);
    while (la.size() > 0 || lb.size() > 0) begin
      if ($urandom_range(0, 15) == 0) send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
      if (lb.size() == 0 || (la.size() > 0 && $urandom_range(0, 1) == 1)) begin
        send_item(OP_APPEND_FIRST, la[0].doc_id, la[0].frequency);
        void'(la.pop_front());
      end else begin
        send_item(OP_APPEND_SECOND, lb[0].doc_id, lb[0].frequency);
        void'(lb.pop_front());
      end
    end
    send_item(OP_MERGE, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // merge with both lists empty
    send_item(OP_MERGE, 16'hFFFF, 16'hFFFF);
    // field extremes and equal frequencies across the lists
    send_item(OP_APPEND_FIRST, 16'hFFFF, 16'hFFFF);
    send_item(OP_APPEND_SECOND, 16'h0000, 16'hFFFF);
    send_item(OP_APPEND_FIRST, 16'h0000, 16'h0000);
    send_item(OP_APPEND_SECOND, 16'hFFFF, 16'h0000);
    send_item(OP_MERGE, 16'h0000, 16'h0000);
    // ignored opcode leaves the lists empty
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(OP_MERGE, 16'h5555, 16'hAAAA);
    // second list only
    send_item(OP_APPEND_SECOND, 16'h0001, 16'd300);
    send_item(OP_APPEND_SECOND, 16'h0002, 16'd200);
    send_item(OP_MERGE, 16'h0000, 16'h0000);
    // unsorted first list is merged as given
    send_item(OP_APPEND_FIRST, 16'h0003, 16'd10);
    send_item(OP_APPEND_FIRST, 16'h0004, 16'd500);
    send_item(OP_APPEND_SECOND, 16'h0005, 16'd100);
    send_item(OP_MERGE, 16'h0000, 16'h0000);
    // first list only, single entry
    send_item(OP_APPEND_FIRST, 16'hAAAA, 16'h5555);
    send_item(OP_MERGE, 16'h0000, 16'h0000);

    // both lists full with drops, the longest merge
    run_batch(1'b1);
    while (items_sent < RANDOM_ITEMS) run_batch(1'b0);

    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
